FILE: rtl/strict_priority_queue_ecn_mark_assert.svh
// Assertion macros for the strict priority queue. Every check is sampled on
// the rising clock edge and is switched off while the reset is asserted.
`ifndef STRICT_PRIORITY_QUEUE_ECN_MARK_ASSERT_SVH
`define STRICT_PRIORITY_QUEUE_ECN_MARK_ASSERT_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every edge.
`define SPQ_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("strict priority queue: assertion failed");

// A condition that must be followed by another one on the next edge.
`define SPQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("strict priority queue: sequencing assertion failed");

`else

`define SPQ_ASSERT(name, prop)
`define SPQ_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: rtl/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned PROD_W      = 30;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned BYTES_W     = 16;
  localparam int unsigned PRIO_W      = 8;
  localparam int unsigned OUT_CLASS_W = 3;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam int unsigned CLASSES_W   = 4;
  localparam int unsigned LIMIT_W     = 16;
  localparam int unsigned MEAN_W      = 14;
  localparam int unsigned THRESH_W    = 16;

  localparam logic [CLASSES_W-1:0] CLASSES_RST = 4'd8;
  localparam logic [LIMIT_W-1:0]   LIMIT_RST   = 16'd512;
  localparam logic [MEAN_W-1:0]    MEAN_RST    = 14'd1500;
  localparam logic [THRESH_W-1:0]  THRESH_RST  = 16'd65;

  localparam logic [PROD_W-1:0] LIMIT_BYTES_RST  = PROD_W'(512 * 1500);
  localparam logic [PROD_W-1:0] THRESH_BYTES_RST = PROD_W'(65 * 1500);

  typedef enum logic {
    CMD_ENQUEUE = 1'b0,
    CMD_DEQUEUE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ACCEPTED = 2'd0,
    ST_DROPPED  = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLASSES_IN_USE = 3'd0,
    CFG_LIMIT_PACKETS  = 3'd1,
    CFG_MEAN_BYTES     = 3'd2,
    CFG_MARK_THRESHOLD = 3'd3,
    CFG_DEQUEUE_MARK   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    cmd_e                 command;
    logic [ID_W-1:0]      packet_id;
    logic [PRIO_W-1:0]    priority_req;
    logic [BYTES_W-1:0]   packet_bytes;
    logic                 ect;
    logic                 ce_in;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic [ID_W-1:0]          out_packet_id;
    logic [BYTES_W-1:0]       out_packet_bytes;
    logic                     ce_mark;
    logic [OUT_CLASS_W-1:0]   out_class;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_write_t;

  // One stored packet descriptor.
  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BYTES_W-1:0] bytes;
    logic               ect;
    logic               ce;
  } desc_t;

endpackage

`default_nettype wire

FILE: rtl/spq_stream_if.sv
`default_nettype none

interface spq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/strict_priority_queue_ecn_mark.sv
`default_nettype none
`include "strict_priority_queue_ecn_mark_assert.svh"

// Channel   Dir  Payload       Transfer
// --------  ---  ------------  -----------------------------------------
// in_i      in   in_item_t     enqueue or dequeue command, valid & ready
// out_o     out  out_item_t    one result per command, valid & ready
// cfg_i     in   cfg_write_t   register write by index, always ready
//
// The block takes one command per cycle while its output is free or taken.
// A result passes through an input register, the descriptor memory's read
// register and the output register. The pace is set by the single write
// and single read port of the descriptor memory, one of each per cycle.
// Reset clears all queue pointers, counts, the byte total and the config
// registers; the descriptor memory is not cleared. When the output is not
// taken the whole pipeline holds and in_i.ready drops in the same cycle.

module strict_priority_queue_ecn_mark #(
  parameter int unsigned NUM_CLASSES = 8,
  parameter int unsigned CLASS_DEPTH = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  spq_stream_if.sink            in_i,
  spq_stream_if.source          out_o,
  spq_stream_if.sink            cfg_i
);
  import spq_pkg::*;

  localparam int unsigned CW       = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned PW       = $clog2(CLASS_DEPTH);
  localparam int unsigned CNTW     = $clog2(CLASS_DEPTH + 1);
  localparam int unsigned DEPTH_ALL = NUM_CLASSES * CLASS_DEPTH;
  localparam int unsigned AW       = $clog2(DEPTH_ALL);

  // What travels from the queue update stage to the result stage.
  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     id;
    logic                ce;
    logic [CW-1:0]       cls;
    logic [TOTAL_W-1:0]  total;
  } s2_t;

  // ---------------------------------------------------------------------
  // Configuration registers and the byte limits derived from them.
  // ---------------------------------------------------------------------
  logic [CLASSES_W-1:0] cfg_classes_q;
  logic [LIMIT_W-1:0]   cfg_limit_q;
  logic [MEAN_W-1:0]    cfg_mean_q;
  logic [THRESH_W-1:0]  cfg_thresh_q;
  logic                 cfg_deq_mark_q;
  logic [PROD_W-1:0]    limit_bytes_q;
  logic [PROD_W-1:0]    thresh_bytes_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_classes_q  <= CLASSES_RST;
      cfg_limit_q    <= LIMIT_RST;
      cfg_mean_q     <= MEAN_RST;
      cfg_thresh_q   <= THRESH_RST;
      cfg_deq_mark_q <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.data.index))
        CFG_CLASSES_IN_USE: cfg_classes_q  <= cfg_i.data.wdata[CLASSES_W-1:0];
        CFG_LIMIT_PACKETS:  cfg_limit_q    <= cfg_i.data.wdata[LIMIT_W-1:0];
        CFG_MEAN_BYTES:     cfg_mean_q     <= cfg_i.data.wdata[MEAN_W-1:0];
        CFG_MARK_THRESHOLD: cfg_thresh_q   <= cfg_i.data.wdata[THRESH_W-1:0];
        CFG_DEQUEUE_MARK:   cfg_deq_mark_q <= cfg_i.data.wdata[0];
        default: ;
      endcase
    end
  end

  // The products follow the registers in the next cycle, which is well within
  // the quiet time required around a configuration write.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_bytes_q  <= LIMIT_BYTES_RST;
      thresh_bytes_q <= THRESH_BYTES_RST;
    end else begin
      limit_bytes_q  <= PROD_W'(cfg_limit_q) * PROD_W'(cfg_mean_q);
      thresh_bytes_q <= PROD_W'(cfg_thresh_q) * PROD_W'(cfg_mean_q);
    end
  end

  // Index of the last class in use. Zero classes behaves as one, and a count
  // above the number of built classes behaves as all of them.
  logic [CW-1:0] last_cls;

  always_comb begin
    if (cfg_classes_q == '0) begin
      last_cls = '0;
    end else if ({1'b0, cfg_classes_q} > 5'(NUM_CLASSES)) begin
      last_cls = CW'(NUM_CLASSES - 1);
    end else begin
      last_cls = CW'(cfg_classes_q - 4'd1);
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline control. All stages move together when the output register
  // is free or being emptied.
  // ---------------------------------------------------------------------
  logic      adv;
  logic      in_v_q;
  in_item_t  in_q;
  logic      s2_v_q;
  s2_t       s2_q;
  s2_t       s2_d;
  logic      out_v_q;
  out_item_t out_q;
  out_item_t out_d;

  assign adv        = !out_v_q || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (adv) begin
      in_v_q  <= in_i.valid;
      s2_v_q  <= in_v_q;
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q  <= in_i.data;
      s2_q  <= s2_d;
      out_q <= out_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: class choice, admission and queue pointer update.
  // ---------------------------------------------------------------------
  logic [PW-1:0]      head_q [NUM_CLASSES];
  logic [PW-1:0]      tail_q [NUM_CLASSES];
  logic [CNTW-1:0]    cnt_q  [NUM_CLASSES];
  logic [TOTAL_W-1:0] total_q;
  logic [TOTAL_W-1:0] total_fwd;
  logic [TOTAL_W-1:0] s2_total_new;

  logic               is_deq;
  logic [CW-1:0]      enq_cls;
  logic               deq_found;
  logic [CW-1:0]      deq_cls;
  logic [CW-1:0]      sel_cls;
  logic [PW-1:0]      head_sel;
  logic [PW-1:0]      tail_sel;
  logic [CNTW-1:0]    cnt_sel;
  logic [TOTAL_W:0]   sum;
  logic               over_limit;
  logic               cls_full;
  logic               enq_ok;
  logic               deq_hit;
  logic               ce_store;
  logic               fire1;
  logic [AW-1:0]      mem_addr;

  assign is_deq = (in_q.command == CMD_DEQUEUE);
  assign fire1  = adv && in_v_q;

  // A priority beyond the classes in use lands in the last one.
  assign enq_cls = (in_q.priority_req <= PRIO_W'(last_cls)) ?
                   CW'(in_q.priority_req) : last_cls;

  // Lowest numbered nonempty class among those in use.
  always_comb begin
    deq_found = 1'b0;
    deq_cls   = '0;
    for (int c = 0; c < NUM_CLASSES; c++) begin
      if (!deq_found && (CW'(c) <= last_cls) && (cnt_q[c] != '0)) begin
        deq_found = 1'b1;
        deq_cls   = CW'(c);
      end
    end
  end

  assign sel_cls  = is_deq ? deq_cls : enq_cls;
  assign head_sel = head_q[sel_cls];
  assign tail_sel = tail_q[sel_cls];
  assign cnt_sel  = cnt_q[sel_cls];

  // The byte total seen by this command includes the one just ahead of it,
  // whose dequeue size only now arrives from the memory.
  assign total_fwd = s2_v_q ? s2_total_new : total_q;

  assign sum        = {1'b0, total_fwd} + (TOTAL_W + 1)'(in_q.packet_bytes);
  assign over_limit = sum > (TOTAL_W + 1)'(limit_bytes_q);
  assign cls_full   = cnt_sel >= CNTW'(CLASS_DEPTH);
  assign enq_ok     = !is_deq && !over_limit && !cls_full;
  assign deq_hit    = is_deq && deq_found;
  assign ce_store   = in_q.ce_in ||
                      (!cfg_deq_mark_q && in_q.ect &&
                       (sum > (TOTAL_W + 1)'(thresh_bytes_q)));

  assign mem_addr = AW'(sel_cls) * AW'(CLASS_DEPTH) +
                    AW'(is_deq ? head_sel : tail_sel);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head_q[c] <= '0;
        tail_q[c] <= '0;
        cnt_q[c]  <= '0;
      end
    end else if (fire1) begin
      if (enq_ok) begin
        tail_q[sel_cls] <= (tail_sel == PW'(CLASS_DEPTH - 1)) ? '0 : tail_sel + 1'b1;
        cnt_q[sel_cls]  <= cnt_sel + 1'b1;
      end else if (deq_hit) begin
        head_q[sel_cls] <= (head_sel == PW'(CLASS_DEPTH - 1)) ? '0 : head_sel + 1'b1;
        cnt_q[sel_cls]  <= cnt_sel - 1'b1;
      end
    end
  end

  always_comb begin
    s2_d.id    = in_q.packet_id;
    s2_d.cls   = sel_cls;
    s2_d.total = total_fwd;
    s2_d.ce    = in_q.ce_in;
    if (is_deq) begin
      s2_d.status = deq_found ? ST_DEQUEUED : ST_EMPTY;
    end else if (enq_ok) begin
      s2_d.status = ST_ACCEPTED;
      s2_d.total  = sum[TOTAL_W-1:0];
      s2_d.ce     = ce_store;
    end else begin
      s2_d.status = ST_DROPPED;
    end
  end

  // ---------------------------------------------------------------------
  // Descriptor memory: one write and one registered read per cycle. A slot
  // is only read after it has been written by an accepted enqueue.
  // ---------------------------------------------------------------------
  desc_t mem [DEPTH_ALL];
  desc_t rd_q;

  always_ff @(posedge clk_i) begin
    if (fire1 && enq_ok) begin
      mem[mem_addr] <= '{id: in_q.packet_id, bytes: in_q.packet_bytes,
                         ect: in_q.ect, ce: ce_store};
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire1 && deq_hit) begin
      rd_q <= mem[mem_addr];
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: byte total after a dequeue, dequeue marking and the result.
  // ---------------------------------------------------------------------
  logic [TOTAL_W-1:0] after_deq;

  assign after_deq = (total_q >= TOTAL_W'(rd_q.bytes)) ?
                     total_q - TOTAL_W'(rd_q.bytes) : '0;

  assign s2_total_new = (s2_q.status == ST_DEQUEUED) ? after_deq : s2_q.total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (adv && s2_v_q) begin
      total_q <= s2_total_new;
    end
  end

  always_comb begin
    out_d.status           = s2_q.status;
    out_d.out_packet_id    = s2_q.id;
    out_d.out_packet_bytes = '0;
    out_d.ce_mark          = s2_q.ce;
    out_d.out_class        = OUT_CLASS_W'(s2_q.cls);
    case (s2_q.status)
      ST_DEQUEUED: begin
        out_d.out_packet_id    = rd_q.id;
        out_d.out_packet_bytes = rd_q.bytes;
        out_d.ce_mark          = rd_q.ce ||
                                 (cfg_deq_mark_q && rd_q.ect &&
                                  (after_deq > TOTAL_W'(thresh_bytes_q)));
      end
      ST_EMPTY: begin
        out_d.out_packet_id = '0;
        out_d.ce_mark       = 1'b0;
        out_d.out_class     = '0;
      end
      default: ;
    endcase
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `SPQ_ASSERT(a_cnt_bound, in_v_q |-> (cnt_sel <= CNTW'(CLASS_DEPTH)))
  `SPQ_ASSERT(a_total_limit, (s2_v_q && (s2_q.status == ST_ACCEPTED)) |-> (s2_q.total <= TOTAL_W'(limit_bytes_q)))
  `SPQ_ASSERT_NEXT(a_s2_to_out, adv && s2_v_q, out_v_q)
  `SPQ_ASSERT(a_empty_zero, (out_v_q && (out_q.status == ST_EMPTY)) |-> ((out_q.out_packet_id == '0) && (out_q.out_packet_bytes == '0) && !out_q.ce_mark))

endmodule

`default_nettype wire

FILE: test/tb_strict_priority_queue_ecn_mark.sv
`timescale 1ns / 100ps

// Testbench for the strict priority queue with ECN marking. Commands go into
// the block over in_i and results come back over out_o, one result per
// command. Each command is predicted when its transfer happens, and each
// result transfer is checked against the oldest prediction.
module tb_strict_priority_queue_ecn_mark;
  import spq_pkg::*;

  localparam int unsigned NUM_CLASSES    = 8;
  localparam int unsigned CLASS_DEPTH    = 64;
  // Three register stages between a command and its result.
  localparam int unsigned LATENCY        = 3;
  localparam int unsigned SETTLE_CYCLES  = LATENCY + 3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SHOWN_ERRORS   = 10;
  localparam int unsigned HOLD_CYCLES    = 300;

  logic clk_i;
  logic rst_ni;

  spq_stream_if #(.payload_t(in_item_t))   in_if ();
  spq_stream_if #(.payload_t(out_item_t))  out_if ();
  spq_stream_if #(.payload_t(cfg_write_t)) cfg_if ();

  strict_priority_queue_ecn_mark #(
    .NUM_CLASSES(NUM_CLASSES),
    .CLASS_DEPTH(CLASS_DEPTH)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Shadow copy of the queue state, kept in step with every command
  // transfer. The descriptor store is only read at slots that an enqueue
  // has filled, so its initial contents never matter.
  desc_t                descriptor_shadow [NUM_CLASSES * CLASS_DEPTH];
  int unsigned          head_slot [NUM_CLASSES];
  int unsigned          tail_slot [NUM_CLASSES];
  int unsigned          class_fill [NUM_CLASSES];
  logic [TOTAL_W-1:0]   bytes_held;

  // Shadow copy of the configuration registers.
  logic [CLASSES_W-1:0] classes_reg;
  logic [LIMIT_W-1:0]   limit_reg;
  logic [MEAN_W-1:0]    mean_reg;
  logic [THRESH_W-1:0]  threshold_reg;
  logic                 dequeue_mark_reg;

  // Results still owed by the block, oldest first.
  out_item_t            pending_results [$];

  int unsigned mismatch_count;
  int unsigned results_checked;
  int unsigned enqueue_count;
  int unsigned dequeue_count;
  int unsigned accepted_count;
  int unsigned dropped_count;
  int unsigned empty_count;
  int unsigned ce_out_count;
  int unsigned register_writes;

  // Pacing controls for both sides of the block.
  bit          sender_throttle;
  bit          receiver_throttle;
  int unsigned receiver_hold_request;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly no gap, sometimes a short one and now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Zero and values above the class count are folded into range.
  function automatic int unsigned active_classes();
    if (classes_reg == 0) return 1;
    if (classes_reg > NUM_CLASSES) return NUM_CLASSES;
    return classes_reg;
  endfunction

  function automatic int unsigned packets_in_active_classes();
    int unsigned total;
    total = 0;
    for (int unsigned c = 0; c < active_classes(); c++) total += class_fill[c];
    return total;
  endfunction

  // Works out the result of one command and moves the shadow state on.
  function automatic out_item_t predict_queue_result(in_item_t cmd);
    int unsigned     nact;
    int unsigned     cls;
    int unsigned     c;
    longint unsigned sum;
    longint unsigned limit_bytes;
    longint unsigned mark_bytes;
    desc_t           slot;
    out_item_t       res;
    nact        = active_classes();
    limit_bytes = 64'(limit_reg) * 64'(mean_reg);
    mark_bytes  = 64'(threshold_reg) * 64'(mean_reg);
    res         = '0;
    if (cmd.command == CMD_ENQUEUE) begin
      sum = 64'(bytes_held) + 64'(cmd.packet_bytes);
      cls = (cmd.priority_req < nact) ? cmd.priority_req : nact - 1;
      res.out_packet_id = cmd.packet_id;
      res.out_class     = OUT_CLASS_W'(cls);
      if (sum > limit_bytes || class_fill[cls] >= CLASS_DEPTH) begin
        // A drop leaves every piece of state alone.
        res.status  = ST_DROPPED;
        res.ce_mark = cmd.ce_in;
      end else begin
        slot.id    = cmd.packet_id;
        slot.bytes = cmd.packet_bytes;
        slot.ect   = cmd.ect;
        slot.ce    = cmd.ce_in | (!dequeue_mark_reg && sum > mark_bytes && cmd.ect);
        descriptor_shadow[cls * CLASS_DEPTH + tail_slot[cls]] = slot;
        tail_slot[cls]  = (tail_slot[cls] + 1) % CLASS_DEPTH;
        class_fill[cls] = class_fill[cls] + 1;
        bytes_held      = sum[TOTAL_W-1:0];
        res.status      = ST_ACCEPTED;
        res.ce_mark     = slot.ce;
      end
    end else begin
      res.status = ST_EMPTY;
      for (c = 0; c < nact; c++) begin
        if (res.status == ST_EMPTY && class_fill[c] > 0) begin
          slot          = descriptor_shadow[c * CLASS_DEPTH + head_slot[c]];
          head_slot[c]  = (head_slot[c] + 1) % CLASS_DEPTH;
          class_fill[c] = class_fill[c] - 1;
          bytes_held    = (bytes_held >= slot.bytes) ? bytes_held - slot.bytes : '0;
          // Dequeue marking looks at what is left behind the packet.
          if (dequeue_mark_reg && 64'(bytes_held) > mark_bytes && slot.ect) slot.ce = 1'b1;
          res.status           = ST_DEQUEUED;
          res.out_packet_id    = slot.id;
          res.out_packet_bytes = slot.bytes;
          res.ce_mark          = slot.ce;
          res.out_class        = OUT_CLASS_W'(c);
        end
      end
    end
    return res;
  endfunction

  function automatic in_item_t make_enqueue(logic [ID_W-1:0] id, logic [PRIO_W-1:0] prio,
                                            logic [BYTES_W-1:0] bytes, logic ect, logic ce);
    in_item_t cmd;
    cmd.command      = CMD_ENQUEUE;
    cmd.packet_id    = id;
    cmd.priority_req = prio;
    cmd.packet_bytes = bytes;
    cmd.ect          = ect;
    cmd.ce_in        = ce;
    return cmd;
  endfunction

  // A dequeue carries random payload fields, which the block must ignore.
  function automatic in_item_t make_dequeue();
    in_item_t cmd;
    cmd         = make_enqueue(ID_W'($urandom), PRIO_W'($urandom), BYTES_W'($urandom),
                               1'($urandom), 1'($urandom));
    cmd.command = CMD_DEQUEUE;
    return cmd;
  endfunction

  // Random command: priorities and sizes mostly in a window that keeps the
  // queues busy, with a share of full-range values.
  function automatic in_item_t random_command(int unsigned enq_pct, int unsigned prio_max,
                                              int unsigned bytes_max);
    logic [PRIO_W-1:0]  prio;
    logic [BYTES_W-1:0] bytes;
    if ($urandom_range(0, 99) >= enq_pct) return make_dequeue();
    prio  = ($urandom_range(0, 99) < 85) ? PRIO_W'($urandom_range(0, prio_max))
                                         : PRIO_W'($urandom_range(0, 255));
    bytes = ($urandom_range(0, 99) < 90) ? BYTES_W'($urandom_range(1, bytes_max))
                                         : BYTES_W'($urandom_range(1, 65535));
    return make_enqueue(ID_W'($urandom), prio, bytes, 1'($urandom), 1'($urandom));
  endfunction

  // Offers one command and waits for its transfer. Valid is only lowered
  // when a gap is taken, so back-to-back commands keep it high.
  task automatic send_command(in_item_t cmd);
    int unsigned gap;
    out_item_t   predicted;
    gap = sender_throttle ? idle_gap() : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.data  <= cmd;
    do @(posedge clk_i); while (!in_if.ready);
    predicted = predict_queue_result(cmd);
    pending_results.push_back(predicted);
    if (cmd.command == CMD_ENQUEUE) enqueue_count++;
    else dequeue_count++;
    case (predicted.status)
      ST_ACCEPTED: accepted_count++;
      ST_DROPPED:  dropped_count++;
      ST_EMPTY:    empty_count++;
      default: ;
    endcase
    if (predicted.ce_mark && predicted.status inside {ST_ACCEPTED, ST_DEQUEUED})
      ce_out_count++;
  endtask

  // Stops offering commands and waits until every owed result has come,
  // then lets the pipeline settle so the block is idle.
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_register(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    drain_results();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, wdata: value};
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_CLASSES_IN_USE: classes_reg      = value[CLASSES_W-1:0];
      CFG_LIMIT_PACKETS:  limit_reg        = value[LIMIT_W-1:0];
      CFG_MEAN_BYTES:     mean_reg         = value[MEAN_W-1:0];
      CFG_MARK_THRESHOLD: threshold_reg    = value[THRESH_W-1:0];
      CFG_DEQUEUE_MARK:   dequeue_mark_reg = value[0];
      default: ;
    endcase
    register_writes++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_queue_config(int unsigned classes, int unsigned limit_pk,
                                  int unsigned mean, int unsigned thresh_pk, bit deq_mark);
    set_register(CFG_CLASSES_IN_USE, CFG_DATA_W'(classes));
    set_register(CFG_LIMIT_PACKETS, CFG_DATA_W'(limit_pk));
    set_register(CFG_MEAN_BYTES, CFG_DATA_W'(mean));
    set_register(CFG_MARK_THRESHOLD, CFG_DATA_W'(thresh_pk));
    set_register(CFG_DEQUEUE_MARK, CFG_DATA_W'(deq_mark));
  endtask

  // Dequeues everything the active classes hold, then one more to see the
  // empty report.
  task automatic empty_active_classes();
    int unsigned remaining;
    remaining = packets_in_active_classes();
    repeat (remaining + 1) send_command(make_dequeue());
  endtask

  // Reset settings: extremes of every field, clamping of high priorities
  // and marking at enqueue once the threshold is passed.
  task automatic test_reset_defaults();
    send_command(make_enqueue(16'h0000, 8'd0, 16'd1, 1'b0, 1'b0));
    send_command(make_enqueue(16'hffff, 8'd255, 16'hffff, 1'b1, 1'b0));
    // This one pushes the total past the marking threshold.
    send_command(make_enqueue(16'h1234, 8'd3, 16'd40000, 1'b1, 1'b0));
    send_command(make_enqueue(16'h5a5a, 8'd7, 16'd100, 1'b0, 1'b1));
    send_command(make_enqueue(16'ha5a5, 8'd8, 16'd200, 1'b1, 1'b1));
    repeat (6) send_command(make_dequeue());
  endtask

  // Class counts of zero and above the hardware count, and a reduction of
  // the count while packets sit in classes that drop out of use.
  task automatic test_class_count_extremes();
    set_queue_config(0, 512, 1500, 65, 1'b0);
    send_command(make_enqueue(16'h0101, 8'd5, 16'd64, 1'b1, 1'b0));
    send_command(make_dequeue());
    set_register(CFG_CLASSES_IN_USE, 16'd15);
    send_command(make_enqueue(16'h0202, 8'd200, 16'd64, 1'b0, 1'b0));
    send_command(make_enqueue(16'h0303, 8'd1, 16'd64, 1'b0, 1'b0));
    repeat (2) send_command(make_dequeue());
    set_register(CFG_CLASSES_IN_USE, 16'd8);
    send_command(make_enqueue(16'h0606, 8'd6, 16'd500, 1'b0, 1'b0));
    send_command(make_enqueue(16'h0404, 8'd1, 16'd500, 1'b0, 1'b0));
    // With two classes the packet in class six is hidden but still counted.
    set_register(CFG_CLASSES_IN_USE, 16'd2);
    repeat (2) send_command(make_dequeue());
    send_command(make_enqueue(16'h0505, 8'd6, 16'd500, 1'b0, 1'b0));
    send_command(make_dequeue());
    set_register(CFG_CLASSES_IN_USE, 16'd8);
    repeat (2) send_command(make_dequeue());
  endtask

  // Zero limit, zero mean size, and both ends of the marking threshold.
  task automatic test_limit_threshold_extremes();
    set_queue_config(8, 0, 1500, 65, 1'b0);
    send_command(make_enqueue(16'h1111, 8'd0, 16'd1, 1'b1, 1'b0));
    set_queue_config(8, 65535, 0, 0, 1'b0);
    send_command(make_enqueue(16'h2222, 8'd2, 16'd1, 1'b1, 1'b0));
    set_queue_config(8, 65535, 9000, 0, 1'b0);
    send_command(make_enqueue(16'h3333, 8'd2, 16'd10, 1'b1, 1'b0));
    send_command(make_enqueue(16'h4444, 8'd2, 16'd10, 1'b0, 1'b0));
    set_register(CFG_MARK_THRESHOLD, 16'd65535);
    send_command(make_enqueue(16'h5555, 8'd4, 16'hffff, 1'b1, 1'b0));
    empty_active_classes();
  endtask

  // Marking at dequeue depends on the bytes left behind each packet.
  task automatic test_dequeue_marking();
    set_queue_config(8, 100, 100, 1, 1'b1);
    repeat (3) send_command(make_enqueue(ID_W'($urandom), 8'd2, 16'd200, 1'b1, 1'b0));
    send_command(make_enqueue(16'h7777, 8'd2, 16'd150, 1'b0, 1'b0));
    repeat (5) send_command(make_dequeue());
  endtask

  // The receiver holds off for a long stretch while enqueues keep coming,
  // so the pipeline fills and stalls its input. Once the single class is
  // full, further packets are dropped.
  task automatic test_backpressure_class_full();
    set_queue_config(1, 65535, 9000, 100, 1'b0);
    sender_throttle       = 1'b0;
    receiver_hold_request = HOLD_CYCLES;
    repeat (CLASS_DEPTH + 6)
      send_command(make_enqueue(ID_W'($urandom), PRIO_W'($urandom),
                                BYTES_W'($urandom_range(1, 65535)), 1'($urandom),
                                1'($urandom)));
    empty_active_classes();
  endtask

  task automatic run_random_phase(int unsigned count, int unsigned enq_pct,
                                  int unsigned prio_max, int unsigned bytes_max);
    repeat (count) send_command(random_command(enq_pct, prio_max, bytes_max));
    empty_active_classes();
  endtask

  // Random traffic under several settings. The first phase runs without
  // any idling; the others pace both sides at random.
  task automatic test_random_traffic();
    sender_throttle   = 1'b0;
    receiver_throttle = 1'b0;
    set_queue_config(8, 24, 1000, 10, 1'b0);
    run_random_phase(60, 55, 9, 2500);
    sender_throttle   = 1'b1;
    receiver_throttle = 1'b1;
    set_queue_config(3, 40, 700, 12, 1'b1);
    run_random_phase(60, 55, 4, 2000);
    // Generous limit and mostly enqueues, so packets build up in the low classes.
    set_queue_config(15, 65535, 9000, 300, 1'b0);
    run_random_phase(70, 80, 3, 65535);
    set_queue_config(0, 1, 16383, 0, 1'b0);
    run_random_phase(60, 50, 9, 9000);
  endtask

  // Receiver pacing. A hold request stalls out_o for that many cycles;
  // otherwise ready is either held high or dropped for random gaps.
  initial begin : receiver_pacing
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(negedge clk_i);
      if (receiver_hold_request != 0) begin
        stall_left            = receiver_hold_request;
        receiver_hold_request = 0;
      end else if (stall_left == 0 && receiver_throttle) begin
        stall_left = idle_gap();
      end
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Every result transfer is checked against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    out_item_t want;
    out_item_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= SHOWN_ERRORS)
          $display("unexpected result: status %s id %h bytes %h ce %b class %0d",
                   got.status.name(), got.out_packet_id, got.out_packet_bytes,
                   got.ce_mark, got.out_class);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (got.status !== want.status || got.out_packet_id !== want.out_packet_id ||
            got.out_packet_bytes !== want.out_packet_bytes ||
            got.ce_mark !== want.ce_mark || got.out_class !== want.out_class) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_ERRORS) begin
            $display("result %0d: expected status %s id %h bytes %h ce %b class %0d",
                     results_checked, want.status.name(), want.out_packet_id,
                     want.out_packet_bytes, want.ce_mark, want.out_class);
            $display("result %0d:      got status %s id %h bytes %h ce %b class %0d",
                     results_checked, got.status.name(), got.out_packet_id,
                     got.out_packet_bytes, got.ce_mark, got.out_class);
          end
        end
      end
    end
  end

  // Ends the run when no transfer of any kind has happened for too long.
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("no transfer for %0d cycles, giving up", quiet_cycles);
        $display("strict_priority_queue_ecn_mark: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.data       <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.data      <= '0;
    bytes_held       = '0;
    classes_reg      = CLASSES_RST;
    limit_reg        = LIMIT_RST;
    mean_reg         = MEAN_RST;
    threshold_reg    = THRESH_RST;
    dequeue_mark_reg = 1'b0;
    for (int unsigned c = 0; c < NUM_CLASSES; c++) begin
      head_slot[c]  = 0;
      tail_slot[c]  = 0;
      class_fill[c] = 0;
    end
    sender_throttle       = 1'b1;
    receiver_throttle     = 1'b1;
    receiver_hold_request = 0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_class_count_extremes();
    test_limit_threshold_extremes();
    test_dequeue_marking();
    test_backpressure_class_full();
    test_random_traffic();

    drain_results();
    repeat (LATENCY * 4) @(posedge clk_i);
    mismatch_count += pending_results.size();

    $display("covered %0d enqueues and %0d dequeues over %0d register writes",
             enqueue_count, dequeue_count, register_writes);
    $display("%0d accepted, %0d dropped, %0d empty, %0d left with CE; %0d results checked",
             accepted_count, dropped_count, empty_count, ce_out_count, results_checked);
    if (mismatch_count == 0) begin
      $display("strict_priority_queue_ecn_mark: match");
    end else begin
      $display("strict_priority_queue_ecn_mark: mismatch");
    end
    $finish;
  end

endmodule

FILE: strict_priority_queue_ecn_mark.f
+incdir+rtl
rtl/spq_pkg.sv
rtl/spq_stream_if.sv
rtl/strict_priority_queue_ecn_mark.sv
test/tb_strict_priority_queue_ecn_mark.sv
